// ===== rtl/audio_frame_ring_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the audio frame ring buffer
// Clocked on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_RING_BUFFER_ASSERT_SVH
`define AUDIO_FRAME_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AFRB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFRB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFRB_ASSERT_IMP(name, ante, cons, msg)
`define AFRB_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/afrb_pkg.sv =====
// ----------------------------------------------------------------------------
// afrb_pkg
// Shared types, constants and helpers of the audio frame ring buffer.
// ----------------------------------------------------------------------------
package afrb_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int CH_W            = 4;
    localparam int WANT_W          = 4;
    localparam int FRAMES_W        = 13;
    localparam int COUNT_W         = 32;
    localparam int TOTAL_W         = 7;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 104;
    localparam int MAX_OUT_RESULTS = 64;
    localparam int CH_MAX          = 8;

    localparam logic [CH_W-1:0] CH_RESET = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_OPEN,
        ST_COMMIT,
        ST_REPORT,
        ST_READ_START,
        ST_READ_FETCH,
        ST_READ_LOAD
    } afrb_state_t;

    typedef struct packed {
        logic capture;
        logic store_in;
        logic open_store;
        logic commit;
        logic read_start;
        logic read_fetch;
        logic read_load;
        logic report_load;
    } afrb_cmd_t;

    typedef struct packed {
        logic in_write;
        logic in_last;
        logic blk_open;
        logic item_last;
        logic read_empty;
        logic read_final;
        logic out_free;
    } afrb_sts_t;

    function automatic logic [CH_W-1:0] chans_of(input logic [CH_W-1:0] raw);
        logic [CH_W-1:0] c;
        c = raw;
        if (raw == '0)
        begin
            c = CH_W'(1);
        end
        else if (raw > CH_W'(CH_MAX))
        begin
            c = CH_W'(CH_MAX);
        end
        return c;
    endfunction

    // frames that fit into the result budget of one read
    function automatic logic [TOTAL_W-1:0] frame_limit(input logic [CH_W-1:0] c);
        logic [TOTAL_W-1:0] lim;
        unique case (c)
            4'd1:    lim = TOTAL_W'(MAX_OUT_RESULTS / 1);
            4'd2:    lim = TOTAL_W'(MAX_OUT_RESULTS / 2);
            4'd3:    lim = TOTAL_W'(MAX_OUT_RESULTS / 3);
            4'd4:    lim = TOTAL_W'(MAX_OUT_RESULTS / 4);
            4'd5:    lim = TOTAL_W'(MAX_OUT_RESULTS / 5);
            4'd6:    lim = TOTAL_W'(MAX_OUT_RESULTS / 6);
            4'd7:    lim = TOTAL_W'(MAX_OUT_RESULTS / 7);
            default: lim = TOTAL_W'(MAX_OUT_RESULTS / 8);
        endcase
        return lim;
    endfunction

endpackage

// ===== rtl/afrb_recip_div.sv =====
// ----------------------------------------------------------------------------
// afrb_recip_div
// Two-stage divide by a channel count of 1..8 via reciprocal multiply and a
// single correction step. Gives the quotient and the largest multiple of the
// divisor not above the dividend.
// ----------------------------------------------------------------------------
module afrb_recip_div #(
    parameter int XW = 12
) (
    input  logic                      clk,
    input  logic [XW-1:0]             x,
    input  logic [afrb_pkg::CH_W-1:0] c,
    output logic [XW-1:0]             quo,
    output logic [XW-1:0]             mult
);
    import afrb_pkg::*;

    localparam logic [XW:0] RECIP [0:7] = '{
        (XW+1)'((1 << XW) / 1),
        (XW+1)'((1 << XW) / 2),
        (XW+1)'((1 << XW) / 3),
        (XW+1)'((1 << XW) / 4),
        (XW+1)'((1 << XW) / 5),
        (XW+1)'((1 << XW) / 6),
        (XW+1)'((1 << XW) / 7),
        (XW+1)'((1 << XW) / 8)
    };

    logic [2:0]      idx;
    logic [2*XW:0]   prod;
    logic [XW-1:0]   q0_reg;
    logic [XW-1:0]   x1_reg;
    logic [CH_W-1:0] c1_reg;
    logic [XW+3:0]   qc;
    logic [XW-1:0]   r_full;
    logic            fix;
    logic [XW-1:0]   quo_reg;
    logic [XW-1:0]   mult_reg;

    assign idx  = 3'(c - 4'd1);
    assign prod = (2*XW+1)'(x) * (2*XW+1)'(RECIP[idx]);

    always_ff @(posedge clk)
    begin
        q0_reg <= XW'(prod[2*XW:XW]);
        x1_reg <= x;
        c1_reg <= c;
    end

    // estimate is at most one low
    assign qc     = (XW+4)'(q0_reg) * (XW+4)'(c1_reg);
    assign r_full = x1_reg - XW'(qc);
    assign fix    = r_full >= XW'(c1_reg);

    always_ff @(posedge clk)
    begin
        quo_reg  <= fix ? q0_reg + 1'b1 : q0_reg;
        mult_reg <= fix ? XW'(qc) + XW'(c1_reg) : XW'(qc);
    end

    assign quo  = quo_reg;
    assign mult = mult_reg;

endmodule

// ===== rtl/afrb_datapath.sv =====
// ----------------------------------------------------------------------------
// afrb_datapath
// Sample store, cursors, block bookkeeping, status dividers and the output
// register of the audio frame ring buffer.
// ----------------------------------------------------------------------------
`include "audio_frame_ring_buffer_assert.svh"

module afrb_datapath #(
    parameter int RING_SAMPLES    = 4096,
    parameter int MAX_READ_FRAMES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [afrb_pkg::CH_W-1:0]        cfg_wdata,
    input  logic [afrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tuser,
    input  afrb_pkg::afrb_cmd_t              cmd,
    output afrb_pkg::afrb_sts_t              sts,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [afrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser
);
    import afrb_pkg::*;

    localparam int           CW        = $clog2(RING_SAMPLES);
    localparam logic [CW:0]  RING      = (CW+1)'(RING_SAMPLES);
    localparam logic [CW-1:0] LAST_ADDR = CW'(RING_SAMPLES - 1);
    localparam logic [TOTAL_W-1:0] MAX_RD = TOTAL_W'(MAX_READ_FRAMES);

    function automatic logic [CW-1:0] inc_addr(input logic [CW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [CW-1:0] add_wrap(input logic [CW-1:0] a,
                                               input logic [CW-1:0] n);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, n};
        if (s >= RING)
        begin
            s = s - RING;
        end
        return CW'(s);
    endfunction

    logic [CH_W-1:0]     cfg_ch_reg;
    logic [CH_W-1:0]     c;
    logic [CW-1:0]       wc_reg;
    logic [CW-1:0]       rc_reg;
    logic [CW-1:0]       pend_reg;
    logic                blk_open_reg;
    logic [CW-1:0]       allowed_reg;
    logic [CW-1:0]       count_reg;
    logic [COUNT_W-1:0]  underrun_reg;

    logic                item_last_reg;
    logic [SAMPLE_W-1:0] item_sample_reg;
    logic [WANT_W-1:0]   item_want_reg;

    logic [CW-1:0]       at_reg;
    logic [TOTAL_W-1:0]  idx_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  nreal_reg;
    logic [FRAMES_W-1:0] done_reg;

    logic [SAMPLE_W-1:0] mem [RING_SAMPLES];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [SAMPLE_W-1:0] mem_wdata;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_svalid_reg;
    logic                out_last_reg;
    logic [FRAMES_W-1:0] out_done_reg;
    logic [FRAMES_W-1:0] out_rd_reg;
    logic [FRAMES_W-1:0] out_wr_reg;
    logic [COUNT_W-1:0]  out_ur_reg;

    logic [SAMPLE_W-1:0] in_sample;
    logic [WANT_W-1:0]   in_want;

    logic [CW:0]         used_w;
    logic [CW:0]         room_w;
    logic                has_room_w;
    logic [CW-1:0]       free_w;
    logic                room_p1_reg;
    logic                room_p2_reg;
    logic [CW-1:0]       quo_used;
    logic [CW-1:0]       quo_free;
    logic [CW-1:0]       mult_free;
    logic [CW-1:0]       quo_count;
    logic [CW-1:0]       mult_count;
    logic [CW-1:0]       writable_w;
    logic [CW-1:0]       allowed_new;

    logic [TOTAL_W-1:0]  lim;
    logic [WANT_W-1:0]   wanted_eff;
    logic [WANT_W-1:0]   frames_rd;
    logic [7:0]          total_prod;
    logic [7:0]          nreal_prod;
    logic [TOTAL_W-1:0]  total_w;
    logic [TOTAL_W-1:0]  nreal_w;
    logic                short_rd;
    logic                can_store;
    logic                read_final;
    logic                out_free;

    assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign in_want   = s_axis_tdata[SAMPLE_W+WANT_W-1:SAMPLE_W];
    assign c         = chans_of(cfg_ch_reg);

    // occupancy from the committed cursors
    assign used_w     = (wc_reg >= rc_reg) ? {1'b0, wc_reg} - {1'b0, rc_reg}
                                           : RING - {1'b0, rc_reg} + {1'b0, wc_reg};
    assign room_w     = RING - used_w;
    assign has_room_w = room_w >= (CW+1)'(c);
    assign free_w     = CW'(room_w - (CW+1)'(c));

    afrb_recip_div #(.XW(CW)) u_div_used (
        .clk  (clk),
        .x    (CW'(used_w)),
        .c    (c),
        .quo  (quo_used),
        .mult ()
    );

    afrb_recip_div #(.XW(CW)) u_div_free (
        .clk  (clk),
        .x    (free_w),
        .c    (c),
        .quo  (quo_free),
        .mult (mult_free)
    );

    afrb_recip_div #(.XW(CW)) u_div_count (
        .clk  (clk),
        .x    (count_reg),
        .c    (c),
        .quo  (quo_count),
        .mult (mult_count)
    );

    always_ff @(posedge clk)
    begin
        room_p1_reg <= has_room_w;
        room_p2_reg <= room_p1_reg;
    end

    assign writable_w  = room_p2_reg ? quo_free : '0;
    assign allowed_new = room_p2_reg ? mult_free : '0;

    // read request sizing
    assign lim        = (MAX_RD < frame_limit(c)) ? MAX_RD : frame_limit(c);
    assign wanted_eff = ({3'b0, item_want_reg} > lim) ? lim[WANT_W-1:0] : item_want_reg;
    assign frames_rd  = (CW'(wanted_eff) < quo_used) ? wanted_eff : WANT_W'(quo_used);
    assign total_prod = {4'b0, wanted_eff} * {4'b0, c};
    assign nreal_prod = {4'b0, frames_rd} * {4'b0, c};
    assign total_w    = TOTAL_W'(total_prod);
    assign nreal_w    = TOTAL_W'(nreal_prod);
    assign short_rd   = frames_rd < wanted_eff;

    assign can_store  = count_reg < allowed_reg;
    assign read_final = idx_reg == total_reg - 1'b1;
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign mem_we    = (cmd.store_in && can_store) || (cmd.open_store && allowed_new != '0);
    assign mem_wdata = cmd.store_in ? in_sample : item_sample_reg;
    assign mem_re    = cmd.read_fetch || cmd.read_load;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pend_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[at_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch_reg   <= CH_RESET;
            wc_reg       <= '0;
            rc_reg       <= '0;
            pend_reg     <= '0;
            blk_open_reg <= 1'b0;
            allowed_reg  <= '0;
            count_reg    <= '0;
            underrun_reg <= '0;
            idx_reg      <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_ch_reg <= cfg_wdata;
            end
            if (cmd.store_in && can_store)
            begin
                pend_reg  <= inc_addr(pend_reg);
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.open_store)
            begin
                blk_open_reg <= 1'b1;
                allowed_reg  <= allowed_new;
                if (allowed_new != '0)
                begin
                    pend_reg  <= inc_addr(pend_reg);
                    count_reg <= CW'(1);
                end
                else
                begin
                    count_reg <= '0;
                end
            end
            if (cmd.commit)
            begin
                wc_reg       <= add_wrap(wc_reg, mult_count);
                pend_reg     <= add_wrap(wc_reg, mult_count);
                blk_open_reg <= 1'b0;
                allowed_reg  <= '0;
                count_reg    <= '0;
            end
            if (cmd.read_start && total_w != '0)
            begin
                rc_reg       <= add_wrap(rc_reg, CW'(nreal_w));
                underrun_reg <= underrun_reg + {{(COUNT_W-1){1'b0}}, short_rd};
                idx_reg      <= '0;
                total_reg    <= total_w;
            end
            if (cmd.read_load)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_last_reg   <= s_axis_tlast;
            item_sample_reg <= in_sample;
            item_want_reg   <= in_want;
        end
        if (cmd.commit)
        begin
            done_reg <= FRAMES_W'(quo_count);
        end
        if (cmd.read_start)
        begin
            done_reg  <= FRAMES_W'(frames_rd);
            at_reg    <= rc_reg;
            nreal_reg <= nreal_w;
        end
        if (mem_re)
        begin
            at_reg <= inc_addr(at_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.read_load || cmd.report_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_load || cmd.report_load)
        begin
            out_rd_reg <= FRAMES_W'(quo_used);
            out_wr_reg <= FRAMES_W'(writable_w);
            out_ur_reg <= underrun_reg;
        end
        if (cmd.report_load)
        begin
            out_sample_reg <= '0;
            out_svalid_reg <= 1'b0;
            out_last_reg   <= 1'b1;
            out_done_reg   <= done_reg;
        end
        if (cmd.read_load)
        begin
            out_sample_reg <= (idx_reg < nreal_reg) ? rdata_reg : '0;
            out_svalid_reg <= 1'b1;
            out_last_reg   <= read_final;
            out_done_reg   <= read_final ? done_reg : '0;
        end
    end

    assign sts.in_write   = !s_axis_tuser;
    assign sts.in_last    = s_axis_tlast;
    assign sts.blk_open   = blk_open_reg;
    assign sts.item_last  = item_last_reg;
    assign sts.read_empty = total_w == '0;
    assign sts.read_final = read_final;
    assign sts.out_free   = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_svalid_reg;
    assign m_axis_tdata  = {1'b0, out_ur_reg, out_wr_reg, out_rd_reg, out_done_reg,
                            out_sample_reg};

    `AFRB_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= allowed_reg, "block count above allowed space")
    `AFRB_ASSERT_NEXT(a_underrun_on_read, !cmd.read_start, $stable(underrun_reg), "underrun moved outside a read")
    `AFRB_ASSERT_IMP(a_read_index_bounded, 1'b1, idx_reg <= total_reg, "read index past request")

endmodule

// ===== rtl/afrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// afrb_ctrl
// Sequencer of the audio frame ring buffer: accepts transactions, waits for
// the status dividers to settle and steps the datapath through each item.
// ----------------------------------------------------------------------------
`include "audio_frame_ring_buffer_assert.svh"

module afrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    output afrb_pkg::afrb_cmd_t  cmd,
    input  afrb_pkg::afrb_sts_t  sts
);
    import afrb_pkg::*;

    afrb_state_t state_reg;
    afrb_state_t state_next;
    afrb_state_t ret_reg;
    afrb_state_t ret_next;
    logic        settle_reg;
    logic        settle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            settle_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        settle_next   = 1'b0;
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.in_write && sts.blk_open)
                    begin
                        cmd.store_in = 1'b1;
                        if (sts.in_last)
                        begin
                            state_next = ST_SETTLE;
                            ret_next   = ST_COMMIT;
                        end
                    end
                    else if (sts.in_write)
                    begin
                        state_next = ST_SETTLE;
                        ret_next   = ST_OPEN;
                    end
                    else
                    begin
                        state_next = ST_SETTLE;
                        ret_next   = ST_READ_START;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (settle_reg)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    settle_next = 1'b1;
                end
            end
            ST_OPEN:
            begin
                cmd.open_store = 1'b1;
                if (sts.item_last)
                begin
                    state_next = ST_SETTLE;
                    ret_next   = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_SETTLE;
                ret_next   = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ_START:
            begin
                cmd.read_start = 1'b1;
                if (sts.read_empty)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    state_next = ST_SETTLE;
                    ret_next   = ST_READ_FETCH;
                end
            end
            ST_READ_FETCH:
            begin
                cmd.read_fetch = 1'b1;
                state_next     = ST_READ_LOAD;
            end
            ST_READ_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.read_load = 1'b1;
                    if (sts.read_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `AFRB_ASSERT_IMP(a_load_has_room, cmd.read_load || cmd.report_load, sts.out_free, "result loaded into a full output register")
    `AFRB_ASSERT_NEXT(a_settle_bounded, state_reg == ST_SETTLE && settle_reg, state_reg != ST_SETTLE, "settle wait did not end")

endmodule

// ===== rtl/audio_frame_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// audio_frame_ring_buffer
// Ring of 32-bit audio samples holding whole interleaved frames.
// ----------------------------------------------------------------------------
// Slave stream: one transaction per write sample (tuser = 0, tlast marks the
// last sample of a block) or per read request (tuser = 1, frame count in
// tdata). Master stream: results; a write block gives one report on its last
// sample, a read gives channels * frames sample results, or one report when
// zero frames are asked for. cfg_we / cfg_wdata set the channel count; the
// user must write it only while the block is idle; the block has no check.
// Samples inside an open block are taken one per cycle. The first sample of
// a block waits in the settle state for the two-stage status divide. A last
// sample steps through settle, commit and settle to its report (first
// settle and open when it also opens the block); a read steps through settle,
// read start, settle and fetch to its results, then delivers one per cycle
// while the receiver is ready. Reset empties the ring (cursors and underrun
// count to zero, channel count 2); stored samples are not cleared. A stalled
// receiver holds the output register; the next transaction is taken once the
// current one has been handed to the output register.
// ----------------------------------------------------------------------------
module audio_frame_ring_buffer #(
    parameter int RING_SAMPLES    = 4096,
    parameter int MAX_READ_FRAMES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [afrb_pkg::CH_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_in[31:0], wanted_frames[35:32], zero pad
    input  logic [afrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,   // block_last
    input  logic                             s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // sample_out[31:0], frames_done[44:32], readable_frames[57:45],
    // writable_frames[70:58], underrun_count[102:71], zero pad
    output logic [afrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,   // result_last
    output logic                             m_axis_tuser    // sample_valid
);
    import afrb_pkg::*;

    afrb_cmd_t cmd;
    afrb_sts_t sts;

    afrb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    afrb_datapath #(
        .RING_SAMPLES    (RING_SAMPLES),
        .MAX_READ_FRAMES (MAX_READ_FRAMES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
